### rtl/tphc_pkg.sv
package tphc_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_TEMP      = 3'd0;
    localparam logic [2:0] REG_PRESS_LO  = 3'd1;
    localparam logic [2:0] REG_PRESS_HI  = 3'd2;
    localparam logic [2:0] REG_PRESS_HUM = 3'd3;
    localparam logic [2:0] REG_HUM       = 3'd4;

    // divider geometry: one quotient bit per stage, divisor magnitude up to 2^30
    localparam int DivSteps = 64;
    localparam int DivWidth = 31;

    // compensation constants
    localparam logic signed [32:0] PressOffset = 33'sd128000;
    localparam logic [20:0]        PressBase   = 21'd1048576;
    localparam logic [11:0]        PressScale  = 12'd3125;
    localparam logic [63:0]        PressBias   = 64'h0000_8000_0000_0000;
    localparam logic signed [31:0] HumOffset   = 32'sd76800;
    localparam logic signed [31:0] HumMax      = 32'sd419430400;
    localparam logic signed [31:0] HumRoundA   = 32'sd16384;
    localparam logic signed [31:0] HumBiasW    = 32'sd32768;
    localparam logic signed [31:0] HumBiasB    = 32'sd2097152;
    localparam logic [31:0]        HumRoundB   = 32'd8192;
    localparam logic signed [31:0] TempRound   = 32'sd128;
    localparam logic signed [31:0] TempMax     = 32'sd32767;
    localparam logic signed [31:0] TempMin     = -32'sd32768;

    // unpacked calibration coefficients
    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
        logic [7:0]         h1;
        logic signed [15:0] h2;
        logic [7:0]         h3;
        logic signed [15:0] h4;
        logic signed [15:0] h5;
        logic signed [7:0]  h6;
    } t_coeffs;

    // results and flags that ride alongside the divider
    typedef struct packed {
        logic signed [15:0] temp;
        logic [16:0]        hum;
        logic               dz;
        logic               neg;
    } t_side;

endpackage

### rtl/tphc_front.sv
module tphc_front import tphc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [19:0]        i_adc_temperature,
    input  logic [19:0]        i_adc_pressure,
    input  logic [15:0]        i_adc_humidity,
    input  t_coeffs            i_coeffs,
    output logic               o_valid,
    output logic [63:0]        o_num_mag,
    output logic [DivWidth-1:0] o_div_mag,
    output t_side              o_side
);

    localparam int Stages = 14;

    logic [Stages-1:0] r_vld;

    // stage registers
    logic signed [31:0] r_s1_v1;
    logic [31:0]        r_s1_dd;
    logic [19:0]        r_s1_adc_p, r_s2_adc_p, r_s3_adc_p;
    logic [15:0]        r_s1_adc_h, r_s2_adc_h, r_s3_adc_h, r_s4_adc_h;
    logic signed [31:0] r_s2_tf;
    logic signed [15:0] r_s3_temp, r_s4_temp, r_s5_temp, r_s6_temp, r_s7_temp;
    logic signed [15:0] r_s8_temp, r_s9_temp, r_s10_temp, r_s11_temp, r_s12_temp;
    logic signed [15:0] r_s13_temp, r_s14_temp;
    logic signed [32:0] r_s3_q1;
    logic signed [31:0] r_s3_x;
    logic [63:0]        r_s4_sq;
    logic signed [48:0] r_s4_b5, r_s5_b5, r_s6_b5;
    logic signed [48:0] r_s4_d2, r_s5_d2, r_s6_d2;
    logic [20:0]        r_s4_praw, r_s5_praw, r_s6_praw, r_s7_praw;
    logic [31:0]        r_s4_hx5, r_s4_xh6, r_s4_xh3;
    logic signed [48:0] r_s5_alo, r_s5_clo;
    logic [31:0]        r_s5_ahi, r_s5_chi;
    logic signed [31:0] r_s5_a, r_s6_a, r_s7_a, r_s8_a, r_s9_a;
    logic signed [31:0] r_s5_u, r_s5_w;
    logic [63:0]        r_s6_a64, r_s6_c64;
    logic signed [31:0] r_s6_b;
    logic [63:0]        r_s7_q2, r_s7_q1b;
    logic signed [31:0] r_s7_b2;
    logic [63:0]        r_s8_x1, r_s8_pn;
    logic [31:0]        r_s8_bh;
    logic [47:0]        r_s9_elo;
    logic [31:0]        r_s9_ehi;
    logic [43:0]        r_s9_nlo;
    logic [31:0]        r_s9_nhi;
    logic signed [31:0] r_s9_b3;
    logic [63:0]        r_s10_e, r_s10_num, r_s11_num;
    logic signed [31:0] r_s10_hx, r_s11_hx, r_s12_hx, r_s13_hx;
    logic signed [DivWidth-1:0] r_s11_dv;
    logic               r_s11_dz, r_s12_dz, r_s13_dz, r_s14_dz;
    logic signed [16:0] r_s11_s;
    logic [63:0]        r_s12_nmag, r_s13_nmag, r_s14_nmag;
    logic [DivWidth-1:0] r_s12_dmag, r_s13_dmag, r_s14_dmag;
    logic               r_s12_neg, r_s13_neg, r_s14_neg;
    logic [31:0]        r_s12_ss;
    logic [31:0]        r_s13_sh;
    logic [16:0]        r_s14_hum;

    // combinational terms
    logic signed [17:0] s1_a0;
    logic signed [33:0] s1_m1;
    logic signed [16:0] s1_d;
    logic signed [33:0] s1_dd;
    logic signed [31:0] s2_sh;
    logic signed [35:0] s2_m;
    logic signed [31:0] s2_v2;
    logic signed [31:0] s3_t5;
    logic signed [31:0] s3_t;
    logic signed [15:0] s3_sat;
    logic signed [65:0] s4_sq;
    logic signed [63:0] s7_c8;
    logic [31:0]        s5_asum;
    logic signed [33:0] s12_sq;
    logic signed [31:0] s13_sr;
    logic signed [31:0] s14_hy;
    logic [31:0]        s14_clip;

    // temperature front: fine temperature term and saturated result, plus the pressure square and p3 shift
    always_comb begin
        s1_a0 = $signed({1'b0, i_adc_temperature[19:3]}) - $signed({1'b0, i_coeffs.t1, 1'b0});
        s1_m1 = s1_a0 * $signed(i_coeffs.t2);
        s1_d  = $signed({1'b0, i_adc_temperature[19:4]}) - $signed({1'b0, i_coeffs.t1});
        s1_dd = s1_d * s1_d;
        s2_sh = $signed(r_s1_dd) >>> 12;
        s2_m  = $signed(s2_sh[19:0]) * $signed(i_coeffs.t3);
        s2_v2 = $signed(s2_m[31:0]) >>> 14;
        s3_t5 = r_s2_tf + (r_s2_tf <<< 2) + TempRound;
        s3_t  = s3_t5 >>> 8;
        if (s3_t > TempMax) begin
            s3_sat = 16'sh7FFF;
        end else if (s3_t < TempMin) begin
            s3_sat = 16'sh8000;
        end else begin
            s3_sat = s3_t[15:0];
        end
        s4_sq = r_s3_q1 * r_s3_q1;
        // arithmetic shift of the p3 term, kept apart from the unsigned sum
        s7_c8 = $signed(r_s6_c64) >>> 8;
    end

    // humidity terms
    always_comb begin
        s5_asum = {2'b00, r_s4_adc_h, 14'd0} - {i_coeffs.h4[11:0], 20'd0} - r_s4_hx5
                  + HumRoundA;
        s12_sq  = r_s11_s * r_s11_s;
        s13_sr  = $signed(r_s12_ss) >>> 7;
        s14_hy  = r_s13_hx - ($signed(r_s13_sh) >>> 4);
        if (s14_hy < 32'sd0) begin
            s14_clip = '0;
        end else if (s14_hy > HumMax) begin
            s14_clip = HumMax;
        end else begin
            s14_clip = s14_hy;
        end
    end

    // valid bits travel with the words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[Stages-2:0], i_valid};
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1
            r_s1_v1    <= $signed(s1_m1[31:0]) >>> 11;
            r_s1_dd    <= s1_dd[31:0];
            r_s1_adc_p <= i_adc_pressure;
            r_s1_adc_h <= i_adc_humidity;
            // stage 2
            r_s2_tf    <= r_s1_v1 + s2_v2;
            r_s2_adc_p <= r_s1_adc_p;
            r_s2_adc_h <= r_s1_adc_h;
            // stage 3
            r_s3_temp  <= s3_sat;
            r_s3_q1    <= $signed({r_s2_tf[31], r_s2_tf}) - PressOffset;
            r_s3_x     <= r_s2_tf - HumOffset;
            r_s3_adc_p <= r_s2_adc_p;
            r_s3_adc_h <= r_s2_adc_h;
            // stage 4
            r_s4_sq    <= s4_sq[63:0];
            r_s4_b5    <= r_s3_q1 * $signed(i_coeffs.p5);
            r_s4_d2    <= r_s3_q1 * $signed(i_coeffs.p2);
            r_s4_praw  <= PressBase - {1'b0, r_s3_adc_p};
            r_s4_hx5   <= r_s3_x * {{16{i_coeffs.h5[15]}}, i_coeffs.h5};
            r_s4_xh6   <= r_s3_x * {{24{i_coeffs.h6[7]}}, i_coeffs.h6};
            r_s4_xh3   <= r_s3_x * {24'd0, i_coeffs.h3};
            r_s4_temp  <= r_s3_temp;
            r_s4_adc_h <= r_s3_adc_h;
            // stage 5
            r_s5_alo   <= $signed({1'b0, r_s4_sq[31:0]}) * $signed(i_coeffs.p6);
            r_s5_ahi   <= r_s4_sq[63:32] * {{16{i_coeffs.p6[15]}}, i_coeffs.p6};
            r_s5_clo   <= $signed({1'b0, r_s4_sq[31:0]}) * $signed(i_coeffs.p3);
            r_s5_chi   <= r_s4_sq[63:32] * {{16{i_coeffs.p3[15]}}, i_coeffs.p3};
            r_s5_b5    <= r_s4_b5;
            r_s5_d2    <= r_s4_d2;
            r_s5_praw  <= r_s4_praw;
            r_s5_a     <= $signed(s5_asum) >>> 15;
            r_s5_u     <= $signed(r_s4_xh6) >>> 10;
            r_s5_w     <= ($signed(r_s4_xh3) >>> 11) + HumBiasW;
            r_s5_temp  <= r_s4_temp;
            // stage 6
            r_s6_a64   <= {{15{r_s5_alo[48]}}, r_s5_alo} + {r_s5_ahi, 32'd0};
            r_s6_c64   <= {{15{r_s5_clo[48]}}, r_s5_clo} + {r_s5_chi, 32'd0};
            r_s6_b5    <= r_s5_b5;
            r_s6_d2    <= r_s5_d2;
            r_s6_praw  <= r_s5_praw;
            r_s6_a     <= r_s5_a;
            r_s6_b     <= r_s5_u * r_s5_w;
            r_s6_temp  <= r_s5_temp;
            // stage 7
            r_s7_q2    <= r_s6_a64 + {r_s6_b5[46:0], 17'd0}
                          + {{13{i_coeffs.p4[15]}}, i_coeffs.p4, 35'd0};
            r_s7_q1b   <= s7_c8 + {{3{r_s6_d2[48]}}, r_s6_d2, 12'd0};
            r_s7_praw  <= r_s6_praw;
            r_s7_a     <= r_s6_a;
            r_s7_b2    <= (r_s6_b >>> 10) + HumBiasB;
            r_s7_temp  <= r_s6_temp;
            // stage 8
            r_s8_x1    <= r_s7_q1b + PressBias;
            r_s8_pn    <= {12'd0, r_s7_praw, 31'd0} - r_s7_q2;
            r_s8_a     <= r_s7_a;
            r_s8_bh    <= r_s7_b2 * {{16{i_coeffs.h2[15]}}, i_coeffs.h2};
            r_s8_temp  <= r_s7_temp;
            // stage 9
            r_s9_elo   <= r_s8_x1[31:0] * i_coeffs.p1;
            r_s9_ehi   <= r_s8_x1[63:32] * {16'd0, i_coeffs.p1};
            r_s9_nlo   <= r_s8_pn[31:0] * PressScale;
            r_s9_nhi   <= r_s8_pn[63:32] * {20'd0, PressScale};
            r_s9_a     <= r_s8_a;
            r_s9_b3    <= $signed(r_s8_bh + HumRoundB) >>> 14;
            r_s9_temp  <= r_s8_temp;
            // stage 10
            r_s10_e    <= {16'd0, r_s9_elo} + {r_s9_ehi, 32'd0};
            r_s10_num  <= {20'd0, r_s9_nlo} + {r_s9_nhi, 32'd0};
            r_s10_hx   <= r_s9_a * r_s9_b3;
            r_s10_temp <= r_s9_temp;
            // stage 11
            r_s11_dv   <= r_s10_e[63:33];
            r_s11_dz   <= (r_s10_e[63:33] == '0);
            r_s11_num  <= r_s10_num;
            r_s11_s    <= r_s10_hx[31:15];
            r_s11_hx   <= r_s10_hx;
            r_s11_temp <= r_s10_temp;
            // stage 12: operand magnitudes for the divider
            r_s12_nmag <= r_s11_num[63] ? (64'd0 - r_s11_num) : r_s11_num;
            r_s12_dmag <= r_s11_dv[DivWidth-1] ? ('0 - r_s11_dv) : r_s11_dv;
            r_s12_neg  <= r_s11_num[63] ^ r_s11_dv[DivWidth-1];
            r_s12_dz   <= r_s11_dz;
            r_s12_ss   <= s12_sq[31:0];
            r_s12_hx   <= r_s11_hx;
            r_s12_temp <= r_s11_temp;
            // stage 13
            r_s13_nmag <= r_s12_nmag;
            r_s13_dmag <= r_s12_dmag;
            r_s13_neg  <= r_s12_neg;
            r_s13_dz   <= r_s12_dz;
            r_s13_sh   <= s13_sr * {24'd0, i_coeffs.h1};
            r_s13_hx   <= r_s12_hx;
            r_s13_temp <= r_s12_temp;
            // stage 14
            r_s14_nmag <= r_s13_nmag;
            r_s14_dmag <= r_s13_dmag;
            r_s14_neg  <= r_s13_neg;
            r_s14_dz   <= r_s13_dz;
            r_s14_hum  <= s14_clip[28:12];
            r_s14_temp <= r_s13_temp;
        end
    end

    assign o_valid     = r_vld[Stages-1];
    assign o_num_mag   = r_s14_nmag;
    assign o_div_mag   = r_s14_dmag;
    assign o_side.temp = r_s14_temp;
    assign o_side.hum  = r_s14_hum;
    assign o_side.dz   = r_s14_dz;
    assign o_side.neg  = r_s14_neg;

endmodule

### rtl/tphc_div.sv
module tphc_div import tphc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [63:0]         i_num_mag,
    input  logic [DivWidth-1:0] i_div_mag,
    input  t_side               i_side,
    output logic                o_valid,
    output logic [63:0]         o_quo,
    output t_side               o_side
);

    logic [DivSteps-1:0] r_vld;
    logic [DivWidth-1:0] r_rem  [DivSteps];
    logic [63:0]         r_dq   [DivSteps];
    logic [DivWidth-1:0] r_md   [DivSteps];
    t_side               r_side [DivSteps];

    logic [DivWidth-1:0] n_rem  [DivSteps];
    logic [63:0]         n_dq   [DivSteps];

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic logic [DivWidth+63:0] div_step(
        input logic [DivWidth-1:0] rem,
        input logic [63:0]         dq,
        input logic [DivWidth-1:0] md
    );
        logic [DivWidth:0] trial;
        logic [DivWidth:0] diff;
        trial = {rem, dq[63]};
        diff  = trial - {1'b0, md};
        if (trial >= {1'b0, md}) begin
            div_step = {diff[DivWidth-1:0], dq[62:0], 1'b1};
        end else begin
            div_step = {trial[DivWidth-1:0], dq[62:0], 1'b0};
        end
    endfunction

    // next remainder and quotient for every stage
    always_comb begin
        {n_rem[0], n_dq[0]} = div_step('0, i_num_mag, i_div_mag);
        for (int k = 1; k < DivSteps; k++) begin
            {n_rem[k], n_dq[k]} = div_step(r_rem[k-1], r_dq[k-1], r_md[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DivSteps-2:0], i_valid};
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= n_rem[0];
            r_dq[0]   <= n_dq[0];
            r_md[0]   <= i_div_mag;
            r_side[0] <= i_side;
            for (int k = 1; k < DivSteps; k++) begin
                r_rem[k]  <= n_rem[k];
                r_dq[k]   <= n_dq[k];
                r_md[k]   <= r_md[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_vld[DivSteps-1];
    assign o_quo   = r_dq[DivSteps-1];
    assign o_side  = r_side[DivSteps-1];

endmodule

### rtl/tphc_post.sv
module tphc_post import tphc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [63:0]        i_quo,
    input  t_side              i_side,
    input  t_coeffs            i_coeffs,
    output logic               o_valid,
    output logic signed [15:0] o_temperature_centideg,
    output logic [31:0]        o_pressure_q24_8,
    output logic [16:0]        o_humidity_q22_10,
    output logic               o_pressure_divisor_zero
);

    localparam int Stages = 7;

    logic [Stages-1:0] r_vld;
    t_side             r_side [Stages];

    logic [63:0]        r_p1_p, r_p2_p, r_p3_p, r_p4_p, r_p5_p;
    logic [63:0]        r_p2_rll;
    logic [31:0]        r_p2_cross;
    logic signed [48:0] r_p2_m8lo;
    logic [31:0]        r_p2_m8hi;
    logic [63:0]        r_p3_rr, r_p3_m8;
    logic signed [48:0] r_p4_lo;
    logic [31:0]        r_p4_hi;
    logic [63:0]        r_p4_q2, r_p5_q2;
    logic [63:0]        r_p5_q1;
    logic [63:0]        r_p6_s;
    logic [31:0]        r_p7_press;

    logic [63:0] p2_r;
    logic [63:0] p5_sum;

    always_comb begin
        p2_r   = $signed(r_p1_p) >>> 13;
        p5_sum = {{15{r_p4_lo[48]}}, r_p4_lo} + {r_p4_hi, 32'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[Stages-2:0], i_valid};
        end
    end

    // quadratic correction of the divided pressure
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < Stages; k++) begin
                r_side[k] <= r_side[k-1];
            end
            // restore the quotient sign
            r_p1_p     <= i_side.neg ? (64'd0 - i_quo) : i_quo;
            // square and p8 product, split in halves
            r_p2_rll   <= p2_r[31:0] * p2_r[31:0];
            r_p2_cross <= p2_r[31:0] * p2_r[63:32];
            r_p2_m8lo  <= $signed({1'b0, r_p1_p[31:0]}) * $signed(i_coeffs.p8);
            r_p2_m8hi  <= r_p1_p[63:32] * {{16{i_coeffs.p8[15]}}, i_coeffs.p8};
            r_p2_p     <= r_p1_p;
            r_p3_rr    <= r_p2_rll + {r_p2_cross[30:0], 33'd0};
            r_p3_m8    <= {{15{r_p2_m8lo[48]}}, r_p2_m8lo} + {r_p2_m8hi, 32'd0};
            r_p3_p     <= r_p2_p;
            // p9 product
            r_p4_lo    <= $signed({1'b0, r_p3_rr[31:0]}) * $signed(i_coeffs.p9);
            r_p4_hi    <= r_p3_rr[63:32] * {{16{i_coeffs.p9[15]}}, i_coeffs.p9};
            r_p4_q2    <= $signed(r_p3_m8) >>> 19;
            r_p4_p     <= r_p3_p;
            r_p5_q1    <= $signed(p5_sum) >>> 25;
            r_p5_q2    <= r_p4_q2;
            r_p5_p     <= r_p4_p;
            r_p6_s     <= r_p5_p + r_p5_q1 + r_p5_q2;
            // final offset, zero divisor forces pressure to zero
            r_p7_press <= r_side[5].dz ? '0
                        : r_p6_s[39:8] + {{12{i_coeffs.p7[15]}}, i_coeffs.p7, 4'd0};
        end
    end

    assign o_valid                 = r_vld[Stages-1];
    assign o_temperature_centideg  = r_side[Stages-1].temp;
    assign o_pressure_q24_8        = r_p7_press;
    assign o_humidity_q22_10       = r_side[Stages-1].hum;
    assign o_pressure_divisor_zero = r_side[Stages-1].dz;

endmodule

### rtl/tph_sensor_compensation.sv
// channel   | handshake          | payload
// ----------+--------------------+-------------------------------------------------
// input     | i_valid / o_ready  | i_adc_temperature, i_adc_pressure, i_adc_humidity
// output    | o_valid / i_ready  | o_temperature_centideg, o_pressure_q24_8,
//           |                    | o_humidity_q22_10, o_pressure_divisor_zero
// config    | i_cfg_we           | i_cfg_index, i_cfg_data
//
// One word per cycle while the output is not stalled: 14 front stages, 64 divider stages
// (one quotient bit each) and 7 correction stages.
// The 64-bit pressure division sets the depth; its one-bit-per-stage chain is the long part.
// Synchronous active-low reset clears valid bits and calibration registers.
// A stall at the output freezes the whole pipeline; o_ready follows it directly.
module tph_sensor_compensation import tphc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [19:0]        i_adc_temperature,
    input  logic [19:0]        i_adc_pressure,
    input  logic [15:0]        i_adc_humidity,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_temperature_centideg,
    output logic [31:0]        o_pressure_q24_8,
    output logic [16:0]        o_humidity_q22_10,
    output logic               o_pressure_divisor_zero,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    logic [47:0] r_temp_coeffs;
    logic [63:0] r_press_coeffs_low;
    logic [63:0] r_press_coeffs_high;
    logic [47:0] r_press_hum_coeffs;
    logic [39:0] r_hum_coeffs;

    t_coeffs             coeffs;
    logic                en;
    logic                front_valid, div_valid;
    logic [63:0]         front_num, div_quo;
    logic [DivWidth-1:0] front_div;
    t_side               front_side, div_side;

    // calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coeffs       <= '0;
            r_press_coeffs_low  <= '0;
            r_press_coeffs_high <= '0;
            r_press_hum_coeffs  <= '0;
            r_hum_coeffs        <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TEMP:      r_temp_coeffs       <= i_cfg_data[47:0];
                REG_PRESS_LO:  r_press_coeffs_low  <= i_cfg_data;
                REG_PRESS_HI:  r_press_coeffs_high <= i_cfg_data;
                REG_PRESS_HUM: r_press_hum_coeffs  <= i_cfg_data[47:0];
                REG_HUM:       r_hum_coeffs        <= i_cfg_data[39:0];
                default: ;
            endcase
        end
    end

    // coefficient fields
    always_comb begin
        coeffs.t1 = r_temp_coeffs[15:0];
        coeffs.t2 = r_temp_coeffs[31:16];
        coeffs.t3 = r_temp_coeffs[47:32];
        coeffs.p1 = r_press_coeffs_low[15:0];
        coeffs.p2 = r_press_coeffs_low[31:16];
        coeffs.p3 = r_press_coeffs_low[47:32];
        coeffs.p4 = r_press_coeffs_low[63:48];
        coeffs.p5 = r_press_coeffs_high[15:0];
        coeffs.p6 = r_press_coeffs_high[31:16];
        coeffs.p7 = r_press_coeffs_high[47:32];
        coeffs.p8 = r_press_coeffs_high[63:48];
        coeffs.p9 = r_press_hum_coeffs[15:0];
        coeffs.h1 = r_press_hum_coeffs[23:16];
        coeffs.h2 = r_press_hum_coeffs[39:24];
        coeffs.h3 = r_press_hum_coeffs[47:40];
        coeffs.h4 = r_hum_coeffs[15:0];
        coeffs.h5 = r_hum_coeffs[31:16];
        coeffs.h6 = r_hum_coeffs[39:32];
    end

    // pipeline advances when the output register is empty or being taken
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    tphc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (en),
        .i_valid           (i_valid),
        .i_adc_temperature (i_adc_temperature),
        .i_adc_pressure    (i_adc_pressure),
        .i_adc_humidity    (i_adc_humidity),
        .i_coeffs          (coeffs),
        .o_valid           (front_valid),
        .o_num_mag         (front_num),
        .o_div_mag         (front_div),
        .o_side            (front_side)
    );

    tphc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (front_valid),
        .i_num_mag (front_num),
        .i_div_mag (front_div),
        .i_side    (front_side),
        .o_valid   (div_valid),
        .o_quo     (div_quo),
        .o_side    (div_side)
    );

    tphc_post u_post (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_en                    (en),
        .i_valid                 (div_valid),
        .i_quo                   (div_quo),
        .i_side                  (div_side),
        .i_coeffs                (coeffs),
        .o_valid                 (o_valid),
        .o_temperature_centideg  (o_temperature_centideg),
        .o_pressure_q24_8        (o_pressure_q24_8),
        .o_humidity_q22_10       (o_humidity_q22_10),
        .o_pressure_divisor_zero (o_pressure_divisor_zero)
    );

`ifndef SYNTHESIS
    a_dz_press_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pressure_divisor_zero) |-> (o_pressure_q24_8 == '0))
        else $error("pressure not zero with zero divisor");

    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_humidity_q22_10 <= 17'd102400))
        else $error("humidity above full scale");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("input taken while output stalled");
`endif

endmodule

### bench/tb_top.sv
module tb_top;
    import tphc_pkg::*;

    // one raw triple and one compensated reading
    typedef struct {
        logic [19:0] adc_t;
        logic [19:0] adc_p;
        logic [15:0] adc_h;
    } t_raw;

    typedef struct {
        logic signed [15:0] temp;
        logic [31:0]        press;
        logic [16:0]        hum;
        logic               dz;
    } t_reading;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [19:0]        i_adc_temperature = '0;
    logic [19:0]        i_adc_pressure = '0;
    logic [15:0]        i_adc_humidity = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [15:0] o_temperature_centideg;
    logic [31:0]        o_pressure_q24_8;
    logic [16:0]        o_humidity_q22_10;
    logic               o_pressure_divisor_zero;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [63:0]        i_cfg_data = '0;

    t_raw       raw_pending[$];
    t_reading   readings_due[$];
    logic [63:0] calib [5];
    int         errors = 0;
    bit         calm = 1'b0;

    tph_sensor_compensation dut (.*);

    always #2 i_clk = ~i_clk;

    // signed quotient truncated toward zero, min / -1 wraps
    function automatic logic [63:0] div_trunc(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] mn, md, q;
        mn = n[63] ? -n : n;
        md = d[63] ? -d : d;
        q = mn / md;
        return (n[63] ^ d[63]) ? -q : q;
    endfunction

    // integer compensation of one triple against the current calibration
    function automatic t_reading compensate(input t_raw r);
        t_reading res;
        logic signed [31:0] ut, t1, t2, t3, v1, v2, d, tf, t;
        logic signed [31:0] h1, h2, h3, h4, h5, h6, x, a, b, s;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, q1, q2, p, ap;
        ut = {12'b0, r.adc_t};
        t1 = {16'b0, calib[REG_TEMP][15:0]};
        t2 = $signed(calib[REG_TEMP][31:16]);
        t3 = $signed(calib[REG_TEMP][47:32]);
        p1 = {48'b0, calib[REG_PRESS_LO][15:0]};
        p2 = $signed(calib[REG_PRESS_LO][31:16]);
        p3 = $signed(calib[REG_PRESS_LO][47:32]);
        p4 = $signed(calib[REG_PRESS_LO][63:48]);
        p5 = $signed(calib[REG_PRESS_HI][15:0]);
        p6 = $signed(calib[REG_PRESS_HI][31:16]);
        p7 = $signed(calib[REG_PRESS_HI][47:32]);
        p8 = $signed(calib[REG_PRESS_HI][63:48]);
        p9 = $signed(calib[REG_PRESS_HUM][15:0]);
        h1 = {24'b0, calib[REG_PRESS_HUM][23:16]};
        h2 = $signed(calib[REG_PRESS_HUM][39:24]);
        h3 = {24'b0, calib[REG_PRESS_HUM][47:40]};
        h4 = $signed(calib[REG_HUM][15:0]);
        h5 = $signed(calib[REG_HUM][31:16]);
        h6 = $signed(calib[REG_HUM][39:32]);

        // fine temperature and centidegrees
        v1 = (((ut >>> 3) - (t1 <<< 1)) * t2) >>> 11;
        d = (ut >>> 4) - t1;
        v2 = (((d * d) >>> 12) * t3) >>> 14;
        tf = v1 + v2;
        t = (tf * 5 + 128) >>> 8;
        res.temp = (t > 32767) ? 16'sh7fff : (t < -32768) ? 16'sh8000 : t[15:0];

        // pressure, 64-bit path
        q1 = 64'(tf);
        q1 = q1 - 64'sd128000;
        q2 = q1 * q1 * p6;
        q2 = q2 + ((q1 * p5) <<< 17);
        q2 = q2 + (p4 <<< 35);
        q1 = ((q1 * q1 * p3) >>> 8) + ((q1 * p2) <<< 12);
        q1 = (((64'sd1 <<< 47) + q1) * p1) >>> 33;
        res.press = '0;
        res.dz = (q1 == 0);
        if (!res.dz) begin
            ap = {44'b0, r.adc_p};
            p = 64'sd1048576 - ap;
            p = $signed(div_trunc(((p <<< 31) - q2) * 64'sd3125, q1));
            q1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
            q2 = (p8 * p) >>> 19;
            p = ((p + q1 + q2) >>> 8) + (p7 <<< 4);
            res.press = p[31:0];
        end

        // humidity, 32-bit path with clamp
        x = tf - 32'sd76800;
        a = (($signed({16'b0, r.adc_h}) <<< 14) - (h4 <<< 20) - h5 * x + 32'sd16384) >>> 15;
        b = ((x * h6) >>> 10) * (((x * h3) >>> 11) + 32'sd32768);
        b = (b >>> 10) + 32'sd2097152;
        b = ((b * h2) + 32'sd8192) >>> 14;
        x = a * b;
        s = x >>> 15;
        x = x - ((((s * s) >>> 7) * h1) >>> 4);
        if (x < 0) x = 0;
        if (x > 32'sd419430400) x = 32'sd419430400;
        res.hum = x[28:12];
        return res;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    // word driver: holds each word until taken
    int gap_cnt = 0;
    always @(posedge i_clk) begin
        t_raw r;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r.adc_t = i_adc_temperature;
                r.adc_p = i_adc_pressure;
                r.adc_h = i_adc_humidity;
                readings_due.push_back(compensate(r));
            end
            if (!i_valid || o_ready) begin
                if (gap_cnt > 0) begin
                    gap_cnt <= gap_cnt - 1;
                    i_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    gap_cnt <= $urandom_range(0, 2);
                    i_valid <= 1'b0;
                end else if (raw_pending.size() > 0) begin
                    r = raw_pending.pop_front();
                    i_valid <= 1'b1;
                    i_adc_temperature <= r.adc_t;
                    i_adc_pressure <= r.adc_p;
                    i_adc_humidity <= r.adc_h;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random stalls and one long hold-off
    int stall_cnt = 0;
    int rx_count = 0;
    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                rx_count <= rx_count + 1;
                if (readings_due.size() == 0) begin
                    report("unexpected word", o_pressure_q24_8, 0);
                end else begin
                    want = readings_due.pop_front();
                    if (o_temperature_centideg !== want.temp)
                        report("temperature", 32'(o_temperature_centideg), 32'(want.temp));
                    if (o_pressure_q24_8 !== want.press)
                        report("pressure", o_pressure_q24_8, want.press);
                    if (o_humidity_q22_10 !== want.hum)
                        report("humidity", 32'(o_humidity_q22_10), 32'(want.hum));
                    if (o_pressure_divisor_zero !== want.dz)
                        report("divisor flag", 32'(o_pressure_divisor_zero), 32'(want.dz));
                end
            end
            if (stall_cnt > 0) begin
                stall_cnt <= stall_cnt - 1;
                i_ready <= 1'b0;
            end else if (o_valid && i_ready && rx_count == 400) begin
                // long hold so the pipeline fills and pushes back
                stall_cnt <= 300;
                i_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_cnt <= $urandom_range(0, 2);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without progress while work is outstanding
    int quiet = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet <= 0;
        end else if (raw_pending.size() > 0 || i_valid || readings_due.size() > 0) begin
            quiet <= quiet + 1;
            if (quiet > 3000) begin
                $display("tph_sensor_compensation verification failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        logic [63:0] mask;
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_TEMP, REG_PRESS_HUM: mask = 64'h0000_ffff_ffff_ffff;
            REG_PRESS_LO, REG_PRESS_HI: mask = '1;
            REG_HUM: mask = 64'h0000_00ff_ffff_ffff;
            default: mask = '0;
        endcase
        if (mask != 0) calib[idx] = val & mask;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (raw_pending.size() > 0 || i_valid || readings_due.size() > 0);
        repeat (90) @(posedge i_clk);
    endtask

    task automatic add_raw(input logic [19:0] at, input logic [19:0] ap, input logic [15:0] ah);
        t_raw r;
        r.adc_t = at;
        r.adc_p = ap;
        r.adc_h = ah;
        raw_pending.push_back(r);
    endtask

    // mostly plausible conversions near room conditions, some full-range noise
    task automatic add_random(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) != 0)
                add_raw(20'($urandom_range(470000, 560000)),
                        20'($urandom_range(250000, 500000)),
                        16'($urandom_range(0, 65535)));
            else
                add_raw(20'($urandom), 20'($urandom), 16'($urandom));
        end
    endtask

    task automatic load_typical();
        write_reg(REG_TEMP, {16'hfc18, 16'd26435, 16'd27504});
        write_reg(REG_PRESS_LO, {16'd2855, 16'd3024, 16'hd643, 16'd36477});
        write_reg(REG_PRESS_HI, {16'hc6f8, 16'd15500, 16'hfff9, 16'd140});
        write_reg(REG_PRESS_HUM, {8'd0, 16'd370, 8'd75, 16'd6000});
        write_reg(REG_HUM, {8'd30, 16'd50, 16'd313});
    endtask

    task automatic load_all(input logic [63:0] v);
        write_reg(REG_TEMP, v);
        write_reg(REG_PRESS_LO, v);
        write_reg(REG_PRESS_HI, v);
        write_reg(REG_PRESS_HUM, v);
        write_reg(REG_HUM, v);
    endtask

    initial begin
        foreach (calib[k]) calib[k] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset calibration: zero divisor on every word
        add_raw(0, 0, 0);
        add_raw(20'hfffff, 20'hfffff, 16'hffff);
        add_random(10);
        wait_idle();

        // typical calibration, field extremes and writes to unused indexes
        load_typical();
        write_reg(3'd5, '1);
        write_reg(3'd7, 64'h1234_5678_9abc_def0);
        add_raw(0, 0, 0);
        add_raw(20'hfffff, 20'hfffff, 16'hffff);
        add_raw(20'hfffff, 0, 0);
        add_raw(0, 20'hfffff, 16'hffff);
        add_raw(519888, 415148, 30000);
        add_raw(519888, 415148, 0);
        add_raw(519888, 415148, 16'hffff);
        add_raw(20'haaaaa, 20'h55555, 16'haaaa);
        add_raw(20'h55555, 20'haaaaa, 16'h5555);
        add_random(500);
        wait_idle();

        load_all('1);
        add_raw(0, 0, 0);
        add_raw(20'hfffff, 20'hfffff, 16'hffff);
        add_random(100);
        wait_idle();

        load_all(64'h7fff_7fff_7fff_7fff);
        add_random(100);
        wait_idle();

        load_all(64'h8000_8000_8000_8000);
        add_random(100);
        wait_idle();

        // random calibrations, then typical again with no idling
        for (int ph = 0; ph < 6; ph++) begin
            for (int k = 0; k < 5; k++) write_reg(k[2:0], {$urandom, $urandom});
            add_random(120);
            wait_idle();
        end
        load_typical();
        calm = 1'b1;
        add_random(350);
        wait_idle();

        if (errors == 0) begin
            $display("tph_sensor_compensation verification clean");
        end else begin
            $display("tph_sensor_compensation verification failed");
        end
        $finish;
    end
endmodule
